/* hw/rtl/iate_pkg.sv */
// Shared constants, types and codes for the indexed array table engine.
`default_nettype none

package iate_pkg;

  // Table geometry
  localparam int ELEM_BITS = 32;
  localparam int DEPTH     = 256;
  localparam int ADDR_W    = $clog2(DEPTH);
  localparam int CNT_W     = $clog2(DEPTH + 1);

  // Port field widths
  localparam int OPC_W      = 3;
  localparam int IDX_W      = 8;
  localparam int DATA_W     = 32;
  localparam int STAT_W     = 3;
  localparam int CAP_W      = 9;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;

  // Common width for range checks of index, count and capacity
  localparam int CMP_W0 = (CNT_W > IDX_W) ? CNT_W : IDX_W;
  localparam int CMP_W  = (CMP_W0 > CAP_W) ? CMP_W0 : CAP_W;

  // Registered first-hit tree: radix 16 per level
  localparam int TREE_RADIX_W = 4;
  localparam int TREE_RADIX   = 1 << TREE_RADIX_W;
  localparam int TREE_LVLS    = (ADDR_W + TREE_RADIX_W - 1) / TREE_RADIX_W;
  localparam int TREE_LEAVES  = 1 << (TREE_RADIX_W * TREE_LVLS);
  localparam int WAIT_W       = $clog2(TREE_LVLS + 1);

  // Cell payload into the tree: {less_than, equal, element}
  localparam int PAY_W = ELEM_BITS + 2;

  typedef logic [ELEM_BITS-1:0] elem_t;

  localparam elem_t ELEM_SIGN = elem_t'(1) << (ELEM_BITS - 1);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_SIGNED   = CFG_IDX_W'(1);

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(256);

  typedef enum logic [OPC_W-1:0] {
    OP_READ   = 3'd0,
    OP_WRITE  = 3'd1,
    OP_APPEND = 3'd2,
    OP_INSERT = 3'd3,
    OP_DELETE = 3'd4,
    OP_DROP   = 3'd5,
    OP_FIND   = 3'd6,
    OP_SEARCH = 3'd7
  } op_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 3'd0,
    ST_RANGE = 3'd1,
    ST_FULL  = 3'd2,
    ST_EMPTY = 3'd3,
    ST_MISS  = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_LOAD   = 2'd1,
    CELL_INSERT = 2'd2,
    CELL_DELETE = 2'd3
  } cell_op_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_WAIT = 1'b1
  } state_e;

  // Broadcast control to every cell of the chain
  typedef struct packed {
    cell_op_e          op;
    logic [ADDR_W-1:0] pos;
    logic [CNT_W-1:0]  cnt;
    elem_t             value;
    logic              sgn;
    logic              match_eq;
  } cell_ctrl_t;

endpackage

`default_nettype wire

/* hw/rtl/indexed_array_table_engine_core.sv */
// Indexed element table: cell chain, first-hit tree and operation sequencer.
//
// Usage: one operation per input transaction (opcode_i, index_i, value_i), one
// result transaction per operation (read_data_o, result_index_o, status_o,
// element_count_o). Both channels use valid/stall; a transaction moves on a
// rising edge with valid high and stall low. Configuration writes
// (cfg_index_i 0 = capacity limit, 1 = signed compare) go through
// cfg_valid_i/cfg_ready_o; cfg_ready_o is always high, and writes are to be
// issued only while no operation is in flight.
// Path from input transaction to registered result:
//   write, append, insert, delete, drop, a range, full or empty error and a
//     search on an empty table: registered directly from the input; the whole
//     chain of cells shifts or loads together with it.
//   read and find (hit or miss): the result waits for the registered
//     first-hit tree over the cells.
//   search: each probe passes through the registered tree; at most
//     floor(log2 count) + 1 probes.
// One operation is in flight at a time; the next input transaction is taken
// in the cycle after the result is registered, or together with the result
// leaving. While the output is stalled the result holds and input stalls.
// Reset: fill count 0, capacity limit 256, unsigned compare, no result
// pending. Element contents are undefined until written.
`default_nettype none

module indexed_array_table_engine_core (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  // input channel
  input  wire                              in_valid_i,
  output logic                             in_stall_o,
  input  wire  [iate_pkg::OPC_W-1:0]      opcode_i,
  input  wire  [iate_pkg::IDX_W-1:0]      index_i,
  input  wire  [iate_pkg::DATA_W-1:0]     value_i,
  // output channel
  output logic                             out_valid_o,
  input  wire                              out_stall_i,
  output logic [iate_pkg::DATA_W-1:0]     read_data_o,
  output logic [iate_pkg::IDX_W-1:0]      result_index_o,
  output logic [iate_pkg::STAT_W-1:0]     status_o,
  output logic [iate_pkg::CNT_W-1:0]      element_count_o,
  // configuration channel
  input  wire                              cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire  [iate_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire  [iate_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  localparam int DP = iate_pkg::DEPTH;
  localparam int AW = iate_pkg::ADDR_W;
  localparam int CW = iate_pkg::CNT_W;
  localparam int MW = iate_pkg::CMP_W;
  localparam int EB = iate_pkg::ELEM_BITS;

  // Configuration registers
  logic [iate_pkg::CAP_W-1:0] cap_q;
  logic                       sgn_q;

  // Sequencer state
  iate_pkg::state_e           state_q, state_d;
  iate_pkg::op_e              job_q, job_d;
  logic [CW-1:0]              cnt_q, cnt_d;
  logic [AW-1:0]              pos_q, pos_d;
  iate_pkg::elem_t            val_q, val_d;
  logic                       match_q, match_d;
  logic [iate_pkg::WAIT_W-1:0] wait_q, wait_d;
  logic signed [CW:0]         lo_q, lo_d;
  logic signed [CW:0]         hi_q, hi_d;

  // Result register
  logic                       out_valid_q, out_valid_d;
  logic [iate_pkg::DATA_W-1:0] rd_q, rd_d;
  logic [iate_pkg::IDX_W-1:0] ri_q, ri_d;
  iate_pkg::status_e          st_q, st_d;
  logic [CW-1:0]              ec_q, ec_d;

  // Chain and tree
  iate_pkg::cell_ctrl_t       ctrl;
  iate_pkg::elem_t            cell_elem [DP];
  wire                        cell_hit  [DP];
  wire [iate_pkg::PAY_W-1:0]  cell_pay  [DP];
  logic                       t_hit;
  logic [AW-1:0]              t_idx;
  logic [iate_pkg::PAY_W-1:0] t_pay;

  logic                       in_acc;
  logic                       slot_free;
  iate_pkg::op_e              op;
  logic [MW-1:0]              idx_w, cnt_w, cap_w;
  logic signed [CW:0]         nlo, nhi;

  // ---------------------------------------------------------------------------
  // Configuration port
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= iate_pkg::CAP_RESET;
      sgn_q <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        iate_pkg::CFG_CAPACITY: cap_q <= cfg_data_i[iate_pkg::CAP_W-1:0];
        iate_pkg::CFG_SIGNED:   sgn_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Handshake
  assign slot_free  = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != iate_pkg::S_IDLE) || !slot_free;
  assign in_acc     = in_valid_i && !in_stall_o;

  // Operands widened to a common width for range checks
  always_comb begin
    op    = iate_pkg::op_e'(opcode_i);
    idx_w = MW'(index_i);
    cnt_w = MW'(cnt_q);
    cap_w = (MW'(cap_q) > MW'(DP)) ? MW'(DP) : MW'(cap_q);
  end

  // Next search bounds after a probe that missed
  always_comb begin
    nlo = $signed({1'b0, CW'(pos_q)}) + $signed((CW + 1)'(1));
    nhi = $signed({1'b0, CW'(pos_q)}) - $signed((CW + 1)'(1));
  end

  // ---------------------------------------------------------------------------
  // Sequencer: next state, cell control and results
  always_comb begin
    logic [CW:0] lo_u;
    logic [CW:0] hi_u;
    state_d     = state_q;
    job_d       = job_q;
    cnt_d       = cnt_q;
    pos_d       = pos_q;
    val_d       = val_q;
    match_d     = match_q;
    wait_d      = wait_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    out_valid_d = out_valid_q && out_stall_i;
    rd_d        = rd_q;
    ri_d        = ri_q;
    st_d        = st_q;
    ec_d        = ec_q;
    lo_u        = '0;
    hi_u        = '0;

    ctrl.op       = iate_pkg::CELL_HOLD;
    ctrl.pos      = pos_q;
    ctrl.cnt      = cnt_q;
    ctrl.value    = val_q;
    ctrl.sgn      = sgn_q;
    ctrl.match_eq = match_q;

    unique case (state_q)
      iate_pkg::S_IDLE: begin
        if (in_acc) begin
          ctrl.value  = EB'(value_i);
          ctrl.pos    = AW'(index_i);
          val_d       = EB'(value_i);
          job_d       = op;
          pos_d       = AW'(index_i);
          // default: an immediate result
          out_valid_d = 1'b1;
          rd_d        = '0;
          ri_d        = '0;
          st_d        = iate_pkg::ST_OK;
          unique case (op)
            iate_pkg::OP_READ: begin
              if (idx_w >= cnt_w) begin
                st_d = iate_pkg::ST_RANGE;
              end else begin
                ctrl.match_eq = 1'b0;
                match_d       = 1'b0;
                out_valid_d   = 1'b0;
                wait_d        = iate_pkg::WAIT_W'(iate_pkg::TREE_LVLS - 1);
                state_d       = iate_pkg::S_WAIT;
              end
            end
            iate_pkg::OP_WRITE: begin
              if ((idx_w > cnt_w) || (idx_w >= cap_w)) begin
                st_d = iate_pkg::ST_RANGE;
              end else begin
                ctrl.op = iate_pkg::CELL_LOAD;
                if (idx_w == cnt_w) cnt_d = cnt_q + CW'(1);
              end
            end
            iate_pkg::OP_APPEND: begin
              if (cnt_w >= cap_w) begin
                st_d = iate_pkg::ST_FULL;
              end else begin
                ctrl.op  = iate_pkg::CELL_LOAD;
                ctrl.pos = AW'(cnt_q);
                cnt_d    = cnt_q + CW'(1);
              end
            end
            iate_pkg::OP_INSERT: begin
              if (idx_w > cnt_w) begin
                st_d = iate_pkg::ST_RANGE;
              end else if (cnt_w >= cap_w) begin
                st_d = iate_pkg::ST_FULL;
              end else begin
                ctrl.op = iate_pkg::CELL_INSERT;
                cnt_d   = cnt_q + CW'(1);
              end
            end
            iate_pkg::OP_DELETE: begin
              if (cnt_q == '0) begin
                st_d = iate_pkg::ST_EMPTY;
              end else if (idx_w >= cnt_w) begin
                st_d = iate_pkg::ST_RANGE;
              end else begin
                ctrl.op = iate_pkg::CELL_DELETE;
                cnt_d   = cnt_q - CW'(1);
              end
            end
            iate_pkg::OP_DROP: begin
              if (cnt_q == '0) begin
                st_d = iate_pkg::ST_EMPTY;
              end else begin
                cnt_d = cnt_q - CW'(1);
              end
            end
            iate_pkg::OP_FIND: begin
              ctrl.match_eq = 1'b1;
              match_d       = 1'b1;
              out_valid_d   = 1'b0;
              wait_d        = iate_pkg::WAIT_W'(iate_pkg::TREE_LVLS - 1);
              state_d       = iate_pkg::S_WAIT;
            end
            iate_pkg::OP_SEARCH: begin
              if (cnt_q == '0) begin
                st_d = iate_pkg::ST_MISS;
              end else begin
                // first probe at the midpoint of [0, count-1]
                lo_d          = '0;
                hi_d          = $signed({1'b0, cnt_q}) - $signed((CW + 1)'(1));
                hi_u          = {1'b0, cnt_q} - (CW + 1)'(1);
                ctrl.pos      = AW'(hi_u >> 1);
                ctrl.match_eq = 1'b0;
                pos_d         = AW'(hi_u >> 1);
                match_d       = 1'b0;
                out_valid_d   = 1'b0;
                wait_d        = iate_pkg::WAIT_W'(iate_pkg::TREE_LVLS - 1);
                state_d       = iate_pkg::S_WAIT;
              end
            end
            default: ;
          endcase
          ec_d = cnt_d;
        end
      end

      iate_pkg::S_WAIT: begin
        if (wait_q != '0) begin
          wait_d = wait_q - iate_pkg::WAIT_W'(1);
        end else begin
          rd_d = '0;
          ri_d = '0;
          ec_d = cnt_q;
          st_d = iate_pkg::ST_OK;
          unique case (job_q)
            iate_pkg::OP_READ: begin
              rd_d        = iate_pkg::DATA_W'(t_pay[EB-1:0]);
              out_valid_d = 1'b1;
              state_d     = iate_pkg::S_IDLE;
            end
            iate_pkg::OP_FIND: begin
              if (t_hit) begin
                ri_d = iate_pkg::IDX_W'(t_idx);
              end else begin
                st_d = iate_pkg::ST_MISS;
              end
              out_valid_d = 1'b1;
              state_d     = iate_pkg::S_IDLE;
            end
            iate_pkg::OP_SEARCH: begin
              if (t_pay[EB]) begin
                ri_d        = iate_pkg::IDX_W'(pos_q);
                out_valid_d = 1'b1;
                state_d     = iate_pkg::S_IDLE;
              end else begin
                if (t_pay[EB+1]) lo_d = nlo;
                else             hi_d = nhi;
                if (lo_d > hi_d) begin
                  st_d        = iate_pkg::ST_MISS;
                  out_valid_d = 1'b1;
                  state_d     = iate_pkg::S_IDLE;
                end else begin
                  // both bounds are non-negative here
                  lo_u   = lo_d;
                  hi_u   = hi_d;
                  pos_d  = AW'((lo_u + hi_u) >> 1);
                  wait_d = iate_pkg::WAIT_W'(iate_pkg::TREE_LVLS);
                end
              end
            end
            default: begin
              out_valid_d = 1'b1;
              state_d     = iate_pkg::S_IDLE;
            end
          endcase
        end
      end

      default: state_d = iate_pkg::S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= iate_pkg::S_IDLE;
      cnt_q       <= '0;
      wait_q      <= '0;
      out_valid_q <= 1'b0;
      job_q       <= iate_pkg::OP_READ;
      match_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      wait_q      <= wait_d;
      out_valid_q <= out_valid_d;
      job_q       <= job_d;
      match_q     <= match_d;
    end
  end

  // Operand and result data registers
  always_ff @(posedge clk_i) begin
    pos_q <= pos_d;
    val_q <= val_d;
    lo_q  <= lo_d;
    hi_q  <= hi_d;
    rd_q  <= rd_d;
    ri_q  <= ri_d;
    st_q  <= st_d;
    ec_q  <= ec_d;
  end

  assign out_valid_o     = out_valid_q;
  assign read_data_o     = rd_q;
  assign result_index_o  = ri_q;
  assign status_o        = st_q;
  assign element_count_o = ec_q;

  // ---------------------------------------------------------------------------
  // Cell chain
  for (genvar g = 0; g < DP; g++) begin : g_cell
    iate_pkg::elem_t left_e;
    iate_pkg::elem_t right_e;
    if (g == 0) begin : g_first
      assign left_e = '0;
    end else begin : g_mid_l
      assign left_e = cell_elem[g - 1];
    end
    if (g == DP - 1) begin : g_last
      assign right_e = '0;
    end else begin : g_mid_r
      assign right_e = cell_elem[g + 1];
    end

    iate_cell u_cell (
      .clk_i      (clk_i),
      .cell_idx_i (AW'(g)),
      .ctrl_i     (ctrl),
      .left_i     (left_e),
      .right_i    (right_e),
      .elem_o     (cell_elem[g]),
      .hit_o      (cell_hit[g]),
      .pay_o      (cell_pay[g])
    );
  end

  iate_tree u_tree (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .hit_i  (cell_hit),
    .pay_i  (cell_pay),
    .hit_o  (t_hit),
    .idx_o  (t_idx),
    .pay_o  (t_pay)
  );

  // ---------------------------------------------------------------------------
  // Assertions
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(DP))
    else $error("fill count above table depth");

  a_wait_slot_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == iate_pkg::S_WAIT) |-> !out_valid_q)
    else $error("result pending while an operation is in flight");

  a_cnt_only_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_acc |=> (cnt_q == $past(cnt_q)))
    else $error("fill count changed without an input transaction");

  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (cnt_q == $past(cnt_q)) || (cnt_q == $past(cnt_q) + CW'(1))
               || (cnt_q == $past(cnt_q) - CW'(1)))
    else $error("fill count moved by more than one");

  a_probe_in_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == iate_pkg::S_WAIT && job_q == iate_pkg::OP_SEARCH)
      |-> (CW'(pos_q) < cnt_q))
    else $error("search probe outside the filled range");

endmodule

`default_nettype wire

/* hw/rtl/iate_cell.sv */
// One table cell: holds an element, shifts with its neighbors, compares to the target.
`default_nettype none

module iate_cell (
  input  wire                          clk_i,
  input  wire  [iate_pkg::ADDR_W-1:0] cell_idx_i,
  input  iate_pkg::cell_ctrl_t         ctrl_i,
  input  iate_pkg::elem_t              left_i,
  input  iate_pkg::elem_t              right_i,
  output iate_pkg::elem_t              elem_o,
  output logic                         hit_o,
  output logic [iate_pkg::PAY_W-1:0]  pay_o
);

  iate_pkg::elem_t elem_q, elem_d;

  logic [iate_pkg::CNT_W-1:0] pos_ext;
  logic                       in_fill;
  logic                       at_pos;
  logic                       after_pos;
  logic                       lt;
  logic                       eq;
  iate_pkg::elem_t            a_key;
  iate_pkg::elem_t            b_key;

  // Position decode and compare against the broadcast target
  always_comb begin
    pos_ext   = iate_pkg::CNT_W'(cell_idx_i);
    in_fill   = pos_ext < ctrl_i.cnt;
    at_pos    = cell_idx_i == ctrl_i.pos;
    after_pos = cell_idx_i > ctrl_i.pos;
    // signed order: flip the sign bit, then compare unsigned
    a_key     = ctrl_i.sgn ? (elem_q ^ iate_pkg::ELEM_SIGN) : elem_q;
    b_key     = ctrl_i.sgn ? (ctrl_i.value ^ iate_pkg::ELEM_SIGN) : ctrl_i.value;
    lt        = a_key < b_key;
    eq        = elem_q == ctrl_i.value;
  end

  // Next element: hold, load, take left neighbor (insert) or right neighbor (delete)
  always_comb begin
    elem_d = elem_q;
    unique case (ctrl_i.op)
      iate_pkg::CELL_HOLD: elem_d = elem_q;
      iate_pkg::CELL_LOAD: begin
        if (at_pos) elem_d = ctrl_i.value;
      end
      iate_pkg::CELL_INSERT: begin
        if (at_pos) begin
          elem_d = ctrl_i.value;
        end else if (after_pos && (pos_ext <= ctrl_i.cnt)) begin
          elem_d = left_i;
        end
      end
      iate_pkg::CELL_DELETE: begin
        if (!(cell_idx_i < ctrl_i.pos) && ((pos_ext + iate_pkg::CNT_W'(1)) < ctrl_i.cnt)) begin
          elem_d = right_i;
        end
      end
      default: elem_d = elem_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    elem_q <= elem_d;
  end

  assign elem_o = elem_q;
  assign hit_o  = ctrl_i.match_eq ? (eq && in_fill) : at_pos;
  assign pay_o  = {lt, eq, elem_q};

endmodule

`default_nettype wire

/* hw/rtl/iate_tree.sv */
// Registered radix-16 first-hit tree over the cell chain outputs.
`default_nettype none

module iate_tree (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          hit_i [iate_pkg::DEPTH],
  input  wire  [iate_pkg::PAY_W-1:0]  pay_i [iate_pkg::DEPTH],
  output logic                         hit_o,
  output logic [iate_pkg::ADDR_W-1:0] idx_o,
  output logic [iate_pkg::PAY_W-1:0]  pay_o
);

  localparam int LV = iate_pkg::TREE_LVLS;
  localparam int LN = iate_pkg::TREE_LEAVES;
  localparam int RX = iate_pkg::TREE_RADIX;
  localparam int RW = iate_pkg::TREE_RADIX_W;

  logic                        leaf_hit [LN];
  logic [iate_pkg::PAY_W-1:0]  leaf_pay [LN];

  logic                        pick_hit [LV][LN];
  logic [iate_pkg::ADDR_W-1:0] pick_idx [LV][LN];
  logic [iate_pkg::PAY_W-1:0]  pick_pay [LV][LN];

  logic                        hit_q [LV][LN];
  logic [iate_pkg::ADDR_W-1:0] idx_q [LV][LN];
  logic [iate_pkg::PAY_W-1:0]  pay_q [LV][LN];

  // Pad the leaves up to a full power of the radix
  always_comb begin
    for (int s = 0; s < LN; s++) begin
      if (s < iate_pkg::DEPTH) begin
        leaf_hit[s] = hit_i[s];
        leaf_pay[s] = pay_i[s];
      end else begin
        leaf_hit[s] = 1'b0;
        leaf_pay[s] = '0;
      end
    end
  end

  // Each node keeps the lowest-indexed hit among its children
  always_comb begin
    logic                        s_hit;
    logic [iate_pkg::ADDR_W-1:0] s_idx;
    logic [iate_pkg::PAY_W-1:0]  s_pay;
    s_hit = 1'b0;
    s_idx = '0;
    s_pay = '0;
    for (int k = 0; k < LV; k++) begin
      for (int n = 0; n < LN; n++) begin
        pick_hit[k][n] = 1'b0;
        pick_idx[k][n] = '0;
        pick_pay[k][n] = '0;
        if (n < (LN >> (RW * (k + 1)))) begin
          for (int j = RX - 1; j >= 0; j--) begin
            if (k == 0) begin
              s_hit = leaf_hit[n * RX + j];
              s_idx = iate_pkg::ADDR_W'(n * RX + j);
              s_pay = leaf_pay[n * RX + j];
            end else begin
              s_hit = hit_q[k - 1][n * RX + j];
              s_idx = idx_q[k - 1][n * RX + j];
              s_pay = pay_q[k - 1][n * RX + j];
            end
            if (s_hit) begin
              pick_hit[k][n] = 1'b1;
              pick_idx[k][n] = s_idx;
              pick_pay[k][n] = s_pay;
            end
          end
        end
      end
    end
  end

  // Level registers: hit flags are control, index and payload are data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < LV; k++) begin
        for (int n = 0; n < LN; n++) begin
          hit_q[k][n] <= 1'b0;
        end
      end
    end else begin
      for (int k = 0; k < LV; k++) begin
        for (int n = 0; n < LN; n++) begin
          hit_q[k][n] <= pick_hit[k][n];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < LV; k++) begin
      for (int n = 0; n < LN; n++) begin
        idx_q[k][n] <= pick_idx[k][n];
        pay_q[k][n] <= pick_pay[k][n];
      end
    end
  end

  assign hit_o = hit_q[LV - 1][0];
  assign idx_o = idx_q[LV - 1][0];
  assign pay_o = pay_q[LV - 1][0];

endmodule

`default_nettype wire

/* bench/iate_table_checker.sv */
// Result checker for the indexed array table engine: tracks the table and compares every result.
`timescale 1ns / 1ps

module iate_table_checker
  import iate_pkg::*;
(
  input  wire                  clk_i,
  input  wire                  rst_ni,
  // input channel
  input  wire                  in_valid_i,
  input  wire                  in_stall_i,
  input  wire [OPC_W-1:0]      opcode_i,
  input  wire [IDX_W-1:0]      index_i,
  input  wire [DATA_W-1:0]     value_i,
  // output channel
  input  wire                  out_valid_i,
  input  wire                  out_stall_i,
  input  wire [DATA_W-1:0]     read_data_i,
  input  wire [IDX_W-1:0]      result_index_i,
  input  wire [STAT_W-1:0]     status_i,
  input  wire [CNT_W-1:0]      element_count_i,
  // configuration channel
  input  wire                  cfg_valid_i,
  input  wire                  cfg_ready_i,
  input  wire [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire [CFG_DATA_W-1:0] cfg_data_i,
  // totals for the top
  output int                   fail_count_o,
  output int                   pending_o,
  output int                   checked_o
);

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic [IDX_W-1:0]  result_index;
    status_e           status;
    logic [CNT_W-1:0]  count;
  } outcome_t;

  // Shadow copy of the table and its registers
  elem_t            elems [DEPTH];
  int               fill;
  logic [CAP_W-1:0] cap_reg;
  logic             sgn_reg;

  outcome_t outcome_q [$];
  outcome_t want;
  int       fails;
  int       checked;
  int       k;

  // -1, 0 or 1 for a against b under the current ordering
  function automatic int order_of(elem_t a, elem_t b);
    elem_t x;
    elem_t y;
    x = sgn_reg ? (a ^ ELEM_SIGN) : a;
    y = sgn_reg ? (b ^ ELEM_SIGN) : b;
    if (x < y) return -1;
    if (x > y) return 1;
    return 0;
  endfunction

  // Applies one operation to the shadow table and returns its outcome
  function automatic outcome_t apply_table_op(op_e op, int idx, elem_t val);
    outcome_t o;
    int       cap;
    int       i;
    int       lo;
    int       hi;
    int       mid;
    int       c;
    o.read_data    = '0;
    o.result_index = '0;
    o.status       = ST_OK;
    cap = (int'(cap_reg) > DEPTH) ? DEPTH : int'(cap_reg);
    case (op)
      OP_READ: begin
        if (idx >= fill) o.status = ST_RANGE;
        else o.read_data = elems[idx];
      end
      OP_WRITE: begin
        if (idx > fill || idx >= cap) o.status = ST_RANGE;
        else begin
          elems[idx] = val;
          if (idx == fill) fill++;
        end
      end
      OP_APPEND: begin
        if (fill >= cap) o.status = ST_FULL;
        else begin
          elems[fill] = val;
          fill++;
        end
      end
      OP_INSERT: begin
        if (idx > fill) o.status = ST_RANGE;
        else if (fill >= cap) o.status = ST_FULL;
        else begin
          for (i = fill; i > idx; i--) elems[i] = elems[i-1];
          elems[idx] = val;
          fill++;
        end
      end
      OP_DELETE: begin
        if (fill == 0) o.status = ST_EMPTY;
        else if (idx >= fill) o.status = ST_RANGE;
        else begin
          for (i = idx + 1; i < fill; i++) elems[i-1] = elems[i];
          fill--;
        end
      end
      OP_DROP: begin
        if (fill == 0) o.status = ST_EMPTY;
        else fill--;
      end
      OP_FIND: begin
        o.status = ST_MISS;
        for (i = 0; i < fill; i++) begin
          if (order_of(elems[i], val) == 0) begin
            o.status       = ST_OK;
            o.result_index = IDX_W'(i);
            break;
          end
        end
      end
      OP_SEARCH: begin
        // single-midpoint binary search, also followed on unsorted contents
        o.status = ST_MISS;
        lo = 0;
        hi = fill - 1;
        while (lo <= hi) begin
          mid = lo + (hi - lo) / 2;
          c = order_of(elems[mid], val);
          if (c == 0) begin
            o.status       = ST_OK;
            o.result_index = IDX_W'(mid);
            break;
          end
          if (c < 0) lo = mid + 1;
          else hi = mid - 1;
        end
      end
    endcase
    o.count = CNT_W'(fill);
    return o;
  endfunction

  // One line per mismatch, counted
  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] exp_val);
    $display("[%0t] mismatch on %s: got %0h, expected %0h", $time, what, got, exp_val);
    fails++;
  endtask

  // Compare results, follow register writes, predict accepted operations
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (k = 0; k < DEPTH; k++) elems[k] = '0;
      fill    = 0;
      cap_reg = CAP_RESET;
      sgn_reg = 1'b0;
      outcome_q.delete();
      fails   = 0;
      checked = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (outcome_q.size() == 0) begin
          report_mismatch("result with no operation pending", 32'(status_i), '0);
        end else begin
          want = outcome_q.pop_front();
          checked++;
          if (read_data_i !== want.read_data)
            report_mismatch("read_data", read_data_i, want.read_data);
          if (result_index_i !== want.result_index)
            report_mismatch("result_index", 32'(result_index_i), 32'(want.result_index));
          if (status_i !== want.status)
            report_mismatch("status", 32'(status_i), 32'(want.status));
          if (element_count_i !== want.count)
            report_mismatch("element_count", 32'(element_count_i), 32'(want.count));
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_CAPACITY: cap_reg = cfg_data_i;
          CFG_SIGNED:   sgn_reg = cfg_data_i[0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i)
        outcome_q.push_back(apply_table_op(op_e'(opcode_i), int'(index_i), value_i));
    end
    fail_count_o <= fails;
    pending_o    <= outcome_q.size();
    checked_o    <= checked;
  end

endmodule

/* bench/tb.sv */
// Top of the table engine bench: clock, reset, stimulus, flow control and verdict.
`timescale 1ns / 1ps

module tb;
  import iate_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam int LONG_HOLD    = 300;
  localparam int TAIL_CYCLES  = 40;

  typedef enum logic {
    MODE_MIXED  = 1'b0,
    MODE_SORTED = 1'b1
  } mix_e;

  logic                  clk_i        = 1'b0;
  logic                  rst_ni       = 1'b0;
  logic                  in_valid_i   = 1'b0;
  logic [OPC_W-1:0]      opcode_i     = '0;
  logic [IDX_W-1:0]      index_i      = '0;
  logic [DATA_W-1:0]     value_i      = '0;
  logic                  out_stall_i  = 1'b0;
  logic                  cfg_valid_i  = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i  = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i   = '0;
  logic                  in_stall_o;
  logic                  out_valid_o;
  logic [DATA_W-1:0]     read_data_o;
  logic [IDX_W-1:0]      result_index_o;
  logic [STAT_W-1:0]     status_o;
  logic [CNT_W-1:0]      element_count_o;
  logic                  cfg_ready_o;

  int fail_count;
  int pending;
  int checked;

  // Stimulus bookkeeping
  bit            idle_on  = 1'b1;
  bit            hold_req = 1'b0;
  int            cycle_count = 0;
  int            items_sent  = 0;
  int            settings_run = 0;
  logic [8:0]    last_count = '0;
  logic [31:0]   value_pool [8];
  logic [31:0]   sorted_vals [$];
  logic [31:0]   sort_base;
  logic [31:0]   sort_flip;

  indexed_array_table_engine_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .opcode_i        (opcode_i),
    .index_i         (index_i),
    .value_i         (value_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .read_data_o     (read_data_o),
    .result_index_o  (result_index_o),
    .status_o        (status_o),
    .element_count_o (element_count_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  iate_table_checker checker_i (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_i      (in_stall_o),
    .opcode_i        (opcode_i),
    .index_i         (index_i),
    .value_i         (value_i),
    .out_valid_i     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .read_data_i     (read_data_o),
    .result_index_i  (result_index_o),
    .status_i        (status_o),
    .element_count_i (element_count_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_i     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .fail_count_o    (fail_count),
    .pending_o       (pending),
    .checked_o       (checked)
  );

  always #6 clk_i = ~clk_i;

  // Run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("run stopped at the cycle limit of %0d", LIMIT_CYCLES);
      $display("tb failed");
      $finish;
    end
  end

  // Latest fill count seen on the output, used to aim indexes
  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i) last_count <= element_count_o;
  end

  // Receiver: random stall bursts, plus a long hold-off on request
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk_i);
        out_stall_i <= 1'b0;
        hold_req = 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 9)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // One input transaction, with an optional gap before it
  task automatic send_op(input op_e op, input logic [IDX_W-1:0] idx,
                         input logic [DATA_W-1:0] val);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    opcode_i   <= op;
    index_i    <= idx;
    value_i    <= val;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    items_sent++;
  endtask

  // Hold the input until every outstanding result has come back
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // Register write; the caller lowers cfg_valid_i after the last one
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
  endtask

  // Index mostly near the current fill, sometimes anywhere
  function automatic logic [IDX_W-1:0] pick_index(input int span);
    int lim;
    lim = int'(last_count) + span;
    if (lim > 255) lim = 255;
    if (lim < 0) lim = 0;
    if ($urandom_range(0, 4) == 0) return IDX_W'($urandom);
    return IDX_W'($urandom_range(0, lim));
  endfunction

  // Target that is usually held in the sorted run
  function automatic logic [DATA_W-1:0] pick_target();
    if (sorted_vals.size() > 0 && $urandom_range(0, 9) < 7)
      return sorted_vals[$urandom_range(0, sorted_vals.size() - 1)];
    return $urandom;
  endfunction

  // Random operation over arbitrary contents
  task automatic send_mixed();
    int          r;
    op_e         op;
    logic [31:0] val;
    r   = $urandom_range(0, 99);
    val = ($urandom_range(0, 1) == 0) ? value_pool[$urandom_range(0, 7)] : $urandom;
    if (r < 10)      op = op_e'($urandom_range(0, 7));
    else if (r < 24) op = OP_READ;
    else if (r < 38) op = OP_WRITE;
    else if (r < 52) op = OP_APPEND;
    else if (r < 66) op = OP_INSERT;
    else if (r < 76) op = OP_DELETE;
    else if (r < 82) op = OP_DROP;
    else if (r < 92) op = OP_FIND;
    else             op = OP_SEARCH;
    send_op(op, pick_index(1), val);
  endtask

  // Operation that keeps the contents ascending, with some noise
  task automatic send_sorted();
    int          r;
    logic [31:0] v;
    r = $urandom_range(0, 99);
    if (r < 35) begin
      sort_base = sort_base + $urandom_range(1, 1 << 24);
      v = sort_base ^ sort_flip;
      sorted_vals.push_back(v);
      send_op(OP_APPEND, IDX_W'($urandom), v);
    end else if (r < 65) begin
      send_op(OP_SEARCH, IDX_W'($urandom), pick_target());
    end else if (r < 75) begin
      send_op(OP_FIND, IDX_W'($urandom), pick_target());
    end else if (r < 85) begin
      send_op(OP_READ, pick_index(0), $urandom);
    end else if (r < 95) begin
      send_op(OP_DELETE, pick_index(-1), $urandom);
    end else begin
      send_op(op_e'($urandom_range(0, 7)), IDX_W'($urandom), $urandom);
    end
  endtask

  // One register setting followed by a run of operations
  task automatic run_phase(input logic [CAP_W-1:0] cap, input logic sgn, input mix_e mode,
                           input int n, input bit idle, input int hold_at);
    int k;
    drain();
    write_reg(CFG_CAPACITY, cap);
    write_reg(CFG_SIGNED, {8'($urandom), sgn});
    cfg_valid_i <= 1'b0;
    settings_run++;
    idle_on = idle;
    if (mode == MODE_SORTED) begin
      // empty the table from the front, then build an ascending run
      repeat (int'(last_count)) send_op(OP_DELETE, '0, $urandom);
      sorted_vals.delete();
      sort_base = ($urandom_range(0, 1) == 0) ? '0 : 32'($urandom_range(0, 1 << 20));
      sort_flip = sgn ? 32'h8000_0000 : 32'h0;
    end
    for (k = 0; k < n; k++) begin
      if (k == hold_at) hold_req = 1'b1;
      if (mode == MODE_SORTED) send_sorted();
      else send_mixed();
    end
  endtask

  // Main sequence
  initial begin
    value_pool[0] = 32'h0000_0000;
    value_pool[1] = 32'hFFFF_FFFF;
    value_pool[2] = 32'h8000_0000;
    value_pool[3] = 32'h7FFF_FFFF;
    value_pool[4] = $urandom;
    value_pool[5] = $urandom;
    value_pool[6] = $urandom;
    value_pool[7] = $urandom;
    sort_base = '0;
    sort_flip = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed corners at reset settings: empty table, bounds, sorted and unsorted search
    send_op(OP_READ,   8'd0,   32'h0000_0000);
    send_op(OP_DELETE, 8'd0,   32'h0000_0000);
    send_op(OP_DROP,   8'hFF,  32'hFFFF_FFFF);
    send_op(OP_FIND,   8'd0,   32'h0000_0000);
    send_op(OP_SEARCH, 8'd0,   32'h0000_0000);
    send_op(OP_WRITE,  8'd1,   32'h1234_5678);
    send_op(OP_WRITE,  8'd0,   32'h0000_0000);
    send_op(OP_APPEND, 8'd0,   32'hFFFF_FFFF);
    send_op(OP_INSERT, 8'd1,   32'h8000_0000);
    send_op(OP_INSERT, 8'd5,   32'h0000_0001);
    send_op(OP_INSERT, 8'd0,   32'h0000_0000);
    send_op(OP_READ,   8'd1,   32'h0);
    send_op(OP_READ,   8'd3,   32'h0);
    send_op(OP_READ,   8'd4,   32'h0);
    send_op(OP_FIND,   8'd0,   32'h8000_0000);
    send_op(OP_SEARCH, 8'd0,   32'hFFFF_FFFF);
    send_op(OP_SEARCH, 8'd0,   32'h7FFF_FFFF);
    send_op(OP_WRITE,  8'd4,   32'h7FFF_FFFF);
    send_op(OP_SEARCH, 8'd0,   32'h7FFF_FFFF);
    send_op(OP_DELETE, 8'd200, 32'h0);
    send_op(OP_DELETE, 8'd0,   32'h0);
    send_op(OP_WRITE,  8'd255, 32'hA5A5_A5A5);
    send_op(OP_READ,   8'd255, 32'h0);
    send_op(OP_DROP,   8'd0,   32'h0);
    send_op(OP_FIND,   8'd0,   32'h5555_5555);

    // Writes to the unused register indexes must change nothing
    drain();
    write_reg(CFG_IDX_W'(2), CFG_DATA_W'($urandom));
    write_reg(CFG_IDX_W'(3), CFG_DATA_W'($urandom));
    cfg_valid_i <= 1'b0;

    // Random phases across capacity and ordering settings
    run_phase(9'd256, 1'b0, MODE_MIXED, 130, 1'b1, 40);
    run_phase(9'd37,  1'b1, MODE_MIXED, 60,  1'b1, -1);
    run_phase(9'd0,   1'b0, MODE_MIXED, 30,  1'b1, -1);
    run_phase(9'd1,   1'b1, MODE_MIXED, 30,  1'b0, -1);
    run_phase(9'd511, 1'b0, MODE_SORTED, 100, 1'b1, -1);
    run_phase(9'd256, 1'b1, MODE_SORTED, 100, 1'b1, 50);
    run_phase(CAP_W'($urandom_range(2, 255)), 1'($urandom), MODE_MIXED, 70, 1'b1, -1);
    run_phase(9'd255, 1'b0, MODE_MIXED, 80, 1'b0, -1);

    drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    $display("sent %0d operations over %0d register settings, %0d results compared",
             items_sent, settings_run, checked);
    $display("covered empty and full tables, capacity 0 to 511, signed and unsigned search");
    if (fail_count == 0 && pending == 0) $display("tb passed");
    else $display("tb failed");
    $finish;
  end

endmodule
